// ===== hdl/dsas_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the scaled decimal add/sub/mul block.
// No dependencies; imported by dsas_alu and decimal_scaled_add_sub_mul_top.
package dsas_pkg;

    // Field widths of a transaction
    localparam int FUNC_W      = 2;
    localparam int COEF_W      = 32;
    localparam int SCALE_W     = 5;
    // Internal scale register holds the sum of two scales
    localparam int SCALE_REG_W = SCALE_W + 1;

    // Parameter defaults
    localparam int COEF_BITS_DEF = 32;
    localparam int MAX_SCALE_DEF = 31;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_ADD  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SUB  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_MUL  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

    // Divide-by-ten step: 4-bit remainder prepended to a 32-bit chunk,
    // quotient by reciprocal ceil(2^39 / 10), exact for values below 2^38
    localparam int          DIV_CHUNK_W = 32;
    localparam int          DIV_REM_W   = 4;
    localparam int          DIV_VAL_W   = DIV_REM_W + DIV_CHUNK_W;
    localparam int          DIV_SHIFT   = 39;
    localparam logic [DIV_VAL_W-1:0] DIV_RECIP = 36'hCCCCCCCCD;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALIGN,
        ST_COMB,
        ST_MUL,
        ST_MULCHK,
        ST_NORM,
        ST_DIV,
        ST_FIN
    } state_t;

    // Operations of the shared arithmetic unit
    typedef enum logic [2:0] {
        ALU_MUL10,
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV10
    } alu_op_t;

endpackage

// ===== hdl/dsas_alu.sv =====
`timescale 1ns / 1ps
// Shared arithmetic unit: times ten, add, subtract, multiply, divide-by-ten step.
// Depends on dsas_pkg.
module dsas_alu #(
    parameter int COEF_BITS = dsas_pkg::COEF_BITS_DEF
) (
    input  dsas_pkg::alu_op_t                             op,
    input  logic [COEF_BITS-1:0]                          a,
    input  logic [COEF_BITS-1:0]                          b,
    input  logic [dsas_pkg::DIV_CHUNK_W-1:0]              chunk_in,
    input  logic [dsas_pkg::DIV_REM_W-1:0]                rem_in,
    output logic [COEF_BITS-1:0]                          y,
    output logic [2*((COEF_BITS < 32) ? COEF_BITS : 32)-1:0] prod,
    output logic [dsas_pkg::DIV_CHUNK_W-1:0]              chunk_out,
    output logic [dsas_pkg::DIV_REM_W-1:0]                rem_out,
    output logic                                          flag
);
    import dsas_pkg::*;

    localparam int CW    = COEF_BITS;
    localparam int OW    = (CW < 32) ? CW : 32;
    localparam int PRODW = 2 * OW;
    localparam int PRW   = 2 * DIV_VAL_W;

    logic [CW+3:0]          times10;
    logic [CW:0]            sum;
    logic [DIV_VAL_W-1:0]   div_val;
    logic [PRW-1:0]         div_prod;
    logic [DIV_CHUNK_W-1:0] div_q;
    logic [DIV_VAL_W-1:0]   div_q10;

    // Times ten as two shifts; the top bits show an excess over the limit
    assign times10 = ({4'b0, a} << 3) + ({4'b0, a} << 1);

    // Sum with carry; the carry shows an excess over the limit
    assign sum = {1'b0, a} + {1'b0, b};

    // Operand product, operands never exceed 32 bits
    assign prod = PRODW'(a[OW-1:0]) * PRODW'(b[OW-1:0]);

    // One divide-by-ten step over a chunk, most significant chunk first
    assign div_val   = {rem_in, chunk_in};
    assign div_prod  = PRW'(div_val) * PRW'(DIV_RECIP);
    assign div_q     = div_prod[DIV_SHIFT +: DIV_CHUNK_W];
    assign div_q10   = ({4'b0, div_q} << 3) + ({4'b0, div_q} << 1);
    assign chunk_out = div_q;
    assign rem_out   = DIV_REM_W'(div_val - div_q10);

    // Select the result and its flag
    always_comb
    begin
        unique case (op)
            ALU_MUL10:
            begin
                y    = times10[CW-1:0];
                flag = |times10[CW+3:CW];
            end
            ALU_ADD:
            begin
                y    = sum[CW-1:0];
                flag = sum[CW];
            end
            ALU_SUB:
            begin
                y    = a - b;
                flag = (a < b);
            end
            default:
            begin
                y    = a;
                flag = 1'b0;
            end
        endcase
    end

endmodule

// ===== hdl/decimal_scaled_add_sub_mul_top.sv =====
`timescale 1ns / 1ps
// Top level of the scaled decimal add/subtract/multiply block: sequencer and registers.
// Depends on dsas_pkg and dsas_alu.
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+------------------------------------------------
//  request  | start, busy          | func, a_coef, a_scale, b_coef, b_scale
//  result   | done (one-cycle)     | res_coef, res_scale, overflow, negative
//
// A transaction is taken when start is high and busy is low; busy then stays high
// until the result strobe. Add and subtract first apply k times-ten steps, where
// k is the scale difference (one times-ten per cycle); each of the d trailing zero
// digits removed then takes N = ceil(COEF_BITS/32) divide-by-ten steps, all through
// the one shared arithmetic unit. Reset is asynchronous, active low, and returns
// to idle. The receiver cannot stall: done lasts one cycle.
module decimal_scaled_add_sub_mul_top #(
    parameter int COEF_BITS = dsas_pkg::COEF_BITS_DEF,
    parameter int MAX_SCALE = dsas_pkg::MAX_SCALE_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [dsas_pkg::FUNC_W-1:0]       func,
    input  logic [dsas_pkg::COEF_W-1:0]       a_coef,
    input  logic [dsas_pkg::SCALE_W-1:0]      a_scale,
    input  logic [dsas_pkg::COEF_W-1:0]       b_coef,
    input  logic [dsas_pkg::SCALE_W-1:0]      b_scale,
    output logic                              done,
    output logic [dsas_pkg::COEF_W-1:0]       res_coef,
    output logic [dsas_pkg::SCALE_W-1:0]      res_scale,
    output logic                              overflow,
    output logic                              negative
);
    import dsas_pkg::*;

    localparam int CW    = COEF_BITS;
    localparam int OW    = (CW < 32) ? CW : 32;
    localparam int PRODW = 2 * OW;
    localparam int NCH   = (CW + DIV_CHUNK_W - 1) / DIV_CHUNK_W;
    localparam int PW    = NCH * DIV_CHUNK_W;
    localparam int CHW   = (NCH > 1) ? $clog2(NCH) : 1;
    localparam logic [SCALE_REG_W-1:0] MAX_SC = SCALE_REG_W'(MAX_SCALE);

    state_t                  state_reg, state_next;
    logic [CW-1:0]           x_reg, x_next;
    logic [CW-1:0]           y_reg, y_next;
    logic [PRODW-1:0]        prod_reg, prod_next;
    logic [PW-1:0]           work_reg, work_next;
    logic [DIV_REM_W-1:0]    rem_reg, rem_next;
    logic [SCALE_REG_W-1:0]  scale_reg, scale_next;
    logic [SCALE_W-1:0]      cnt_reg, cnt_next;
    logic [CHW-1:0]          chk_reg, chk_next;
    logic                    sel_b_reg, sel_b_next;
    logic [FUNC_W-1:0]       func_reg, func_next;
    logic                    ovf_reg, ovf_next;
    logic                    neg_reg, neg_next;
    logic                    done_reg, done_next;
    logic [COEF_W-1:0]       res_coef_reg, res_coef_next;
    logic [SCALE_W-1:0]      res_scale_reg, res_scale_next;
    logic                    res_ovf_reg, res_ovf_next;
    logic                    res_neg_reg, res_neg_next;

    alu_op_t                 alu_op;
    logic [CW-1:0]           alu_a;
    logic [CW-1:0]           alu_y;
    logic [PRODW-1:0]        alu_prod;
    logic [DIV_CHUNK_W-1:0]  alu_chunk_in;
    logic [DIV_CHUNK_W-1:0]  alu_chunk_out;
    logic [DIV_REM_W-1:0]    alu_rem;
    logic                    alu_flag;
    logic                    in_big;
    logic                    fin_ovf;

    dsas_alu #(
        .COEF_BITS (COEF_BITS)
    ) u_alu (
        .op        (alu_op),
        .a         (alu_a),
        .b         (y_reg),
        .chunk_in  (alu_chunk_in),
        .rem_in    (rem_reg),
        .y         (alu_y),
        .prod      (alu_prod),
        .chunk_out (alu_chunk_out),
        .rem_out   (alu_rem),
        .flag      (alu_flag)
    );

    // Operands beyond the coefficient or scale limits
    assign in_big = ((a_coef >> CW) != '0) || ((b_coef >> CW) != '0) ||
                    ({1'b0, a_scale} > MAX_SC) || ({1'b0, b_scale} > MAX_SC);

    assign alu_chunk_in = work_reg[PW-1 -: DIV_CHUNK_W];
    assign fin_ovf      = ovf_reg || (!neg_reg && (scale_reg > MAX_SC));

    // Advance the sequencer and steer the shared unit
    always_comb
    begin
        state_next     = state_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        prod_next      = prod_reg;
        work_next      = work_reg;
        rem_next       = rem_reg;
        scale_next     = scale_reg;
        cnt_next       = cnt_reg;
        chk_next       = chk_reg;
        sel_b_next     = sel_b_reg;
        func_next      = func_reg;
        ovf_next       = ovf_reg;
        neg_next       = neg_reg;
        done_next      = 1'b0;
        res_coef_next  = res_coef_reg;
        res_scale_next = res_scale_reg;
        res_ovf_next   = res_ovf_reg;
        res_neg_next   = res_neg_reg;
        alu_op         = ALU_MUL10;
        alu_a          = x_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ovf_next  = 1'b0;
                    neg_next  = 1'b0;
                    func_next = func;
                    x_next    = CW'(a_coef);
                    y_next    = CW'(b_coef);
                    if (func == FUNC_NONE)
                    begin
                        x_next     = '0;
                        scale_next = '0;
                        state_next = ST_FIN;
                    end
                    else if (in_big)
                    begin
                        ovf_next   = 1'b1;
                        state_next = ST_FIN;
                    end
                    else if (func == FUNC_MUL)
                    begin
                        scale_next = SCALE_REG_W'(a_scale) + SCALE_REG_W'(b_scale);
                        state_next = ST_MUL;
                    end
                    else if (a_scale >= b_scale)
                    begin
                        scale_next = SCALE_REG_W'(a_scale);
                        cnt_next   = a_scale - b_scale;
                        sel_b_next = 1'b1;
                        state_next = ST_ALIGN;
                    end
                    else
                    begin
                        scale_next = SCALE_REG_W'(b_scale);
                        cnt_next   = b_scale - a_scale;
                        sel_b_next = 1'b0;
                        state_next = ST_ALIGN;
                    end
                end
            end
            ST_ALIGN:
            begin
                // One times-ten per cycle on the operand with the smaller scale
                alu_op = ALU_MUL10;
                alu_a  = sel_b_reg ? y_reg : x_reg;
                if (cnt_reg == '0)
                begin
                    state_next = ST_COMB;
                end
                else if (alu_flag)
                begin
                    ovf_next   = 1'b1;
                    state_next = ST_FIN;
                end
                else
                begin
                    if (sel_b_reg)
                    begin
                        y_next = alu_y;
                    end
                    else
                    begin
                        x_next = alu_y;
                    end
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_COMB:
            begin
                alu_op = (func_reg == FUNC_SUB) ? ALU_SUB : ALU_ADD;
                if (alu_flag)
                begin
                    if (func_reg == FUNC_SUB)
                    begin
                        neg_next = 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    state_next = ST_FIN;
                end
                else
                begin
                    x_next     = alu_y;
                    state_next = ST_NORM;
                end
            end
            ST_MUL:
            begin
                alu_op     = ALU_MUL;
                prod_next  = alu_prod;
                state_next = ST_MULCHK;
            end
            ST_MULCHK:
            begin
                if ((prod_reg >> CW) != '0)
                begin
                    ovf_next   = 1'b1;
                    state_next = ST_FIN;
                end
                else
                begin
                    x_next     = CW'(prod_reg);
                    state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                // Drop one trailing zero digit per pass while the scale allows
                if (scale_reg == '0)
                begin
                    state_next = ST_FIN;
                end
                else if (x_reg == '0)
                begin
                    scale_next = '0;
                    state_next = ST_FIN;
                end
                else
                begin
                    work_next  = PW'(x_reg);
                    rem_next   = '0;
                    chk_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                alu_op    = ALU_DIV10;
                work_next = (work_reg << DIV_CHUNK_W) | PW'(alu_chunk_out);
                rem_next  = alu_rem;
                if (chk_reg == CHW'(NCH - 1))
                begin
                    if (alu_rem == '0)
                    begin
                        x_next     = CW'(work_next);
                        scale_next = scale_reg - 1'b1;
                        state_next = ST_NORM;
                    end
                    else
                    begin
                        state_next = ST_FIN;
                    end
                end
                else
                begin
                    chk_next = chk_reg + 1'b1;
                end
            end
            ST_FIN:
            begin
                // Apply the final scale limit and present the transaction
                res_ovf_next   = fin_ovf;
                res_neg_next   = !fin_ovf && neg_reg;
                res_coef_next  = (fin_ovf || neg_reg) ? '0 : COEF_W'(x_reg);
                res_scale_next = (fin_ovf || neg_reg) ? '0 : SCALE_W'(scale_reg);
                done_next      = 1'b1;
                state_next     = ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Hold the datapath
    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        y_reg         <= y_next;
        prod_reg      <= prod_next;
        work_reg      <= work_next;
        rem_reg       <= rem_next;
        scale_reg     <= scale_next;
        cnt_reg       <= cnt_next;
        chk_reg       <= chk_next;
        sel_b_reg     <= sel_b_next;
        func_reg      <= func_next;
        ovf_reg       <= ovf_next;
        neg_reg       <= neg_next;
        res_coef_reg  <= res_coef_next;
        res_scale_reg <= res_scale_next;
        res_ovf_reg   <= res_ovf_next;
        res_neg_reg   <= res_neg_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign res_coef  = res_coef_reg;
    assign res_scale = res_scale_reg;
    assign overflow  = res_ovf_reg;
    assign negative  = res_neg_reg;

`ifndef NO_ASSERTIONS
    // The result strobe arrives only once the sequencer is back at idle
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while busy");

    // An accepted transaction always raises busy in the cycle after it is taken
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // The strobe lasts one cycle per transaction
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe longer than one cycle");

    // The two flags never stand together
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !(overflow && negative))
        else $error("overflow and negative both raised");

    // A flagged result carries a zero coefficient and scale
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (overflow || negative)) |-> (res_coef == '0 && res_scale == '0))
        else $error("flagged result with nonzero payload");
`endif

endmodule
